### rtl/core/sebp_pkg.sv
// shared types, codes and constants of the sequence event byte parser
package sebp_pkg;

    localparam int DATA_W     = 8;
    localparam int OUT_DATA_W = 136;
    localparam int KIND_W     = 4;

    // reciprocal of 25 applied to the product shifted down by two, exact for 16-bit products
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 17;

    // status bytes with a meaning of their own
    localparam logic [7:0] ST_NOTE_RUN  = 8'h62;
    localparam logic [7:0] ST_NOP_A     = 8'h60;
    localparam logic [7:0] ST_NOP_B     = 8'h61;
    localparam logic [7:0] ST_CTRL_BASE = 8'hC0;
    localparam logic [7:0] ST_REST      = 8'hE0;
    localparam logic [7:0] ST_HOLD      = 8'hE1;
    localparam logic [7:0] ST_PROG      = 8'hE2;
    localparam logic [7:0] ST_TEMPO     = 8'hEA;
    localparam logic [7:0] ST_VOL       = 8'hEE;
    localparam logic [7:0] ST_LOOP      = 8'hFD;
    localparam logic [7:0] ST_JUMP      = 8'hFE;
    localparam logic [7:0] ST_END       = 8'hFF;
    localparam logic [7:0] VEL_FLAG     = 8'h80;

    typedef enum logic [KIND_W-1:0] {
        KIND_NOTE    = 4'd0,
        KIND_HOLD    = 4'd1,
        KIND_PROGRAM = 4'd2,
        KIND_TEMPO   = 4'd3,
        KIND_UNKNOWN = 4'd4,
        KIND_LOOP    = 4'd5,
        KIND_JUMP    = 4'd6,
        KIND_RETURN  = 4'd7,
        KIND_END     = 4'd8
    } t_kind;

    // event on its way from the decoder to the scaling stage
    typedef struct packed {
        t_kind       kind;
        logic [31:0] time_tick;
        logic [31:0] offset;
        logic [2:0]  length;
        logic [6:0]  note;
        logic [6:0]  vel;
        logic [15:0] prod;
        logic [7:0]  value;
        logic [31:0] seek;
    } t_evt;

    typedef struct packed {
        logic       listed;
        logic [1:0] nargs;
    } t_unk;

    // fixed argument count of the listed commands that are only skipped
    function automatic t_unk unk_info(input logic [7:0] s);
        t_unk r;
        r.listed = 1'b1;
        case (s)
            8'hC0, 8'hDE, 8'hE3, 8'hEC, 8'hF0, 8'hF2, 8'hFA: r.nargs = 2'd1;
            8'hCE, 8'hD1, 8'hD2, 8'hD3, 8'hD4, 8'hD5, 8'hD6,
            8'hEF, 8'hF8: r.nargs = 2'd2;
            8'hD0, 8'hE4, 8'hE5, 8'hE7, 8'hE9, 8'hF1, 8'hF3: r.nargs = 2'd3;
            8'hE6, 8'hE8, 8'hF6, 8'hF7: r.nargs = 2'd0;
            default: begin
                r.listed = 1'b0;
                r.nargs  = 2'd0;
            end
        endcase
        return r;
    endfunction

endpackage

### rtl/core/sequence_event_byte_parser_unit.sv
// top level of the sequence event byte parser: input register and stage wiring
// a byte accepted into the input register passes through the event register and then the output register
// throughput: one byte per cycle while the output is not stalled, set by the combinational decode of the parse state
// an output stall backs up through the event and input registers before tready drops
// reset (synchronous, active low) clears parse state, time, offsets and all valid flags
// start_offset resets to zero and is applied at the next track_start transaction
module sequence_event_byte_parser_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [31:0]                         i_cfg_data,     // start_offset
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [sebp_pkg::DATA_W-1:0]         s_axis_tdata,   // data_byte
    input  logic [0:0]                          s_axis_tuser,   // track_start
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // event_time, event_offset, event_length, note_number, velocity,
    // note_length, value_byte, seek_address, zero fill
    output logic [sebp_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    output logic [sebp_pkg::KIND_W-1:0]         m_axis_tuser    // event_kind
);

    logic                           r_in_valid;
    logic [sebp_pkg::DATA_W-1:0]    r_in_byte;
    logic                           r_in_start;

    logic           proc;
    logic           mid_free;
    logic           mid_take;
    logic           mid_valid;
    sebp_pkg::t_evt mid;

    assign o_cfg_ready   = 1'b1;
    assign proc          = r_in_valid && mid_free;
    assign s_axis_tready = !r_in_valid || proc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    sebp_decode u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_proc      (proc),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_mid_take  (mid_take),
        .o_mid_valid (mid_valid),
        .o_mid       (mid),
        .o_mid_free  (mid_free)
    );

    sebp_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mid_valid (mid_valid),
        .i_mid       (mid),
        .o_mid_take  (mid_take),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_kind      (m_axis_tuser)
    );

endmodule

### rtl/core/sebp_decode.sv
// byte decoder: parse state, time keeping and event register
module sebp_decode (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    input  logic [31:0]         i_cfg_data,
    input  logic                i_proc,
    input  logic [7:0]          i_byte,
    input  logic                i_start,
    input  logic                i_mid_take,
    output logic                o_mid_valid,
    output sebp_pkg::t_evt      o_mid,
    output logic                o_mid_free
);

    typedef enum logic [3:0] {
        PH_STATUS     = 4'd0,
        PH_NOTE_DELTA = 4'd1,
        PH_NOTE_DUR   = 4'd2,
        PH_NOTE_VEL   = 4'd3,
        PH_SKIP       = 4'd4,
        PH_REST       = 4'd5,
        PH_HOLD_DELTA = 4'd6,
        PH_HOLD_DUR   = 4'd7,
        PH_PROG       = 4'd8,
        PH_TEMPO      = 4'd9,
        PH_VOL        = 4'd10,
        PH_LOOP       = 4'd11,
        PH_JUMP       = 4'd12
    } t_phase;

    t_phase      r_ph, n_ph;
    logic [7:0]  r_stat, n_stat;
    logic [31:0] r_bp, n_bp;
    logic [31:0] r_cb, n_cb;
    logic [31:0] r_tt, n_tt;
    logic [7:0]  r_rdelta, n_rdelta;
    logic [6:0]  r_rdur, n_rdur;
    logic [7:0]  r_gd, n_gd;
    logic [7:0]  r_gdur, n_gdur;
    logic [31:0] r_ag, n_ag;
    logic [2:0]  r_skip, n_skip;
    logic        r_insub, n_insub;
    logic [31:0] r_ret, n_ret;
    logic        r_ended, n_ended;
    logic [31:0] r_start_off;
    logic        r_mid_valid;
    sebp_pkg::t_evt r_mid;

    sebp_pkg::t_evt evt;
    logic           evt_valid;

    always_comb begin
        logic [31:0]    c_bp;
        logic [31:0]    c_tt;
        t_phase         c_ph;
        logic [6:0]     c_rdur;
        logic [31:0]    bp_inc;
        logic [31:0]    ag_new;
        logic [7:0]     mul_b;
        logic [7:0]     note_sub;
        sebp_pkg::t_unk unk;

        // restart takes effect before the byte of the same transaction
        c_bp   = i_start ? r_start_off : r_bp;
        c_tt   = i_start ? 32'd0 : r_tt;
        c_ph   = i_start ? PH_STATUS : r_ph;
        c_rdur = i_start ? 7'd0 : r_rdur;
        n_bp     = c_bp;
        n_tt     = c_tt;
        n_ph     = c_ph;
        n_rdur   = c_rdur;
        n_rdelta = i_start ? 8'd0 : r_rdelta;
        n_insub  = i_start ? 1'b0 : r_insub;
        n_ret    = i_start ? 32'd0 : r_ret;
        n_skip   = i_start ? 3'd0 : r_skip;
        n_ended  = i_start ? 1'b0 : r_ended;
        n_stat   = r_stat;
        n_cb     = r_cb;
        n_gd     = r_gd;
        n_gdur   = r_gdur;
        n_ag     = r_ag;

        bp_inc   = c_bp + 32'd1;
        ag_new   = {r_ag[23:0], i_byte};
        note_sub = r_stat - sebp_pkg::ST_NOTE_RUN;
        unk      = sebp_pkg::unk_info(i_byte);

        case (c_ph)
            PH_NOTE_DUR: mul_b = {1'b0, c_rdur};
            PH_HOLD_DUR: mul_b = i_byte;
            default:     mul_b = r_gdur;
        endcase

        evt_valid      = 1'b0;
        evt.kind       = sebp_pkg::KIND_NOTE;
        evt.time_tick  = c_tt;
        evt.offset     = r_cb;
        evt.length     = 3'(bp_inc - r_cb);
        evt.note       = 7'd0;
        evt.vel        = 7'd0;
        evt.prod       = 16'(r_gd * mul_b);
        evt.value      = 8'd0;
        evt.seek       = 32'd0;

        if (!n_ended) begin
            if (c_ph == PH_STATUS) begin
                n_cb       = c_bp;
                n_bp       = bp_inc;
                n_stat     = i_byte;
                evt.offset = c_bp;
                evt.length = 3'd1;
                if (i_byte == sebp_pkg::ST_END) begin
                    evt_valid = 1'b1;
                    if (n_insub) begin
                        n_insub   = 1'b0;
                        n_bp      = n_ret;
                        evt.kind  = sebp_pkg::KIND_RETURN;
                        evt.seek  = n_ret;
                    end else begin
                        n_ended  = 1'b1;
                        evt.kind = sebp_pkg::KIND_END;
                    end
                end else if (i_byte == sebp_pkg::ST_NOP_A || i_byte == sebp_pkg::ST_NOP_B) begin
                    n_ph = PH_STATUS;
                end else if (i_byte < sebp_pkg::ST_CTRL_BASE) begin
                    if (i_byte < sebp_pkg::ST_NOTE_RUN) begin
                        n_ph = PH_NOTE_DELTA;
                    end else begin
                        n_gd = n_rdelta;
                        n_ph = PH_NOTE_DUR;
                    end
                end else if (i_byte == sebp_pkg::ST_REST) begin
                    n_ph = PH_REST;
                end else if (i_byte == sebp_pkg::ST_HOLD) begin
                    n_ph = PH_HOLD_DELTA;
                end else if (i_byte == sebp_pkg::ST_PROG) begin
                    n_ph = PH_PROG;
                end else if (i_byte == sebp_pkg::ST_TEMPO) begin
                    n_ph = PH_TEMPO;
                end else if (i_byte == sebp_pkg::ST_VOL) begin
                    n_ph = PH_VOL;
                end else if (i_byte == sebp_pkg::ST_LOOP) begin
                    n_ph   = PH_LOOP;
                    n_skip = 3'd4;
                end else if (i_byte == sebp_pkg::ST_JUMP) begin
                    n_ph   = PH_JUMP;
                    n_skip = 3'd4;
                    n_ag   = 32'd0;
                end else if (!unk.listed) begin
                    n_ended   = 1'b1;
                    evt_valid = 1'b1;
                    evt.kind  = sebp_pkg::KIND_END;
                end else if (unk.nargs == 2'd0) begin
                    evt_valid = 1'b1;
                    evt.kind  = sebp_pkg::KIND_UNKNOWN;
                    evt.value = i_byte;
                end else begin
                    n_skip = {1'b0, unk.nargs};
                    n_ph   = PH_SKIP;
                end
            end else begin
                n_bp = bp_inc;
                n_ph = PH_STATUS;
                case (c_ph)
                    PH_NOTE_DELTA: begin
                        n_gd     = i_byte;
                        n_rdelta = i_byte;
                        n_ph     = PH_NOTE_DUR;
                    end
                    PH_NOTE_DUR, PH_NOTE_VEL: begin
                        if (c_ph == PH_NOTE_DUR && i_byte < sebp_pkg::VEL_FLAG) begin
                            n_gdur = i_byte;
                            n_rdur = i_byte[6:0];
                            n_ph   = PH_NOTE_VEL;
                        end else begin
                            if (c_ph == PH_NOTE_DUR) begin
                                n_gdur = {1'b0, c_rdur};
                            end
                            evt_valid = 1'b1;
                            evt.kind  = sebp_pkg::KIND_NOTE;
                            evt.note  = (r_stat < sebp_pkg::ST_NOTE_RUN) ? r_stat[6:0]
                                                                         : note_sub[6:0];
                            evt.vel   = i_byte[6:0];
                            n_tt      = c_tt + {24'd0, r_gd};
                        end
                    end
                    PH_SKIP, PH_LOOP, PH_JUMP: begin
                        if (c_ph == PH_JUMP) begin
                            n_ag = ag_new;
                        end
                        if (n_skip > 3'd1) begin
                            n_skip = n_skip - 3'd1;
                            n_ph   = c_ph;
                        end else begin
                            n_skip    = 3'd0;
                            evt_valid = 1'b1;
                            if (c_ph == PH_SKIP) begin
                                evt.kind  = sebp_pkg::KIND_UNKNOWN;
                                evt.value = r_stat;
                            end else if (c_ph == PH_LOOP) begin
                                evt.kind = sebp_pkg::KIND_LOOP;
                            end else begin
                                evt.kind = sebp_pkg::KIND_JUMP;
                                evt.seek = ag_new;
                                n_insub  = 1'b1;
                                n_ret    = r_cb + 32'd5;
                                n_bp     = ag_new;
                            end
                        end
                    end
                    PH_REST: begin
                        n_tt = c_tt + {24'd0, i_byte};
                    end
                    PH_HOLD_DELTA: begin
                        n_gd = i_byte;
                        n_ph = PH_HOLD_DUR;
                    end
                    PH_HOLD_DUR: begin
                        n_gdur    = i_byte;
                        evt_valid = 1'b1;
                        evt.kind  = sebp_pkg::KIND_HOLD;
                        n_tt      = c_tt + {24'd0, r_gd};
                    end
                    PH_PROG: begin
                        evt_valid = 1'b1;
                        evt.kind  = sebp_pkg::KIND_PROGRAM;
                        evt.value = i_byte;
                    end
                    PH_TEMPO: begin
                        evt_valid = 1'b1;
                        evt.kind  = sebp_pkg::KIND_TEMPO;
                        evt.value = i_byte;
                    end
                    default: begin
                        n_ph = PH_STATUS;
                    end
                endcase
            end
        end
    end

    assign o_mid_free  = !r_mid_valid || i_mid_take;
    assign o_mid_valid = r_mid_valid;
    assign o_mid       = r_mid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ph        <= PH_STATUS;
            r_stat      <= 8'd0;
            r_bp        <= 32'd0;
            r_cb        <= 32'd0;
            r_tt        <= 32'd0;
            r_rdelta    <= 8'd0;
            r_rdur      <= 7'd0;
            r_gd        <= 8'd0;
            r_gdur      <= 8'd0;
            r_ag        <= 32'd0;
            r_skip      <= 3'd0;
            r_insub     <= 1'b0;
            r_ret       <= 32'd0;
            r_ended     <= 1'b0;
            r_start_off <= 32'd0;
            r_mid_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_start_off <= i_cfg_data;
            end
            if (i_proc) begin
                r_ph        <= n_ph;
                r_stat      <= n_stat;
                r_bp        <= n_bp;
                r_cb        <= n_cb;
                r_tt        <= n_tt;
                r_rdelta    <= n_rdelta;
                r_rdur      <= n_rdur;
                r_gd        <= n_gd;
                r_gdur      <= n_gdur;
                r_ag        <= n_ag;
                r_skip      <= n_skip;
                r_insub     <= n_insub;
                r_ret       <= n_ret;
                r_ended     <= n_ended;
                r_mid_valid <= evt_valid;
            end else if (i_mid_take) begin
                r_mid_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_proc) begin
            r_mid <= evt;
        end
    end

`ifndef NO_ASSERTIONS
    a_jump_enters_sub: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && evt_valid && evt.kind == sebp_pkg::KIND_JUMP) |=> r_insub)
        else $error("jump did not enter subroutine");
    a_end_latches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_proc && evt_valid && evt.kind == sebp_pkg::KIND_END) |=> r_ended)
        else $error("end of track not latched");
    a_ended_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ended |-> (r_ph == PH_STATUS))
        else $error("ended track left in argument phase");
    a_skip_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skip != 3'd0) |-> (r_ph == PH_SKIP || r_ph == PH_LOOP || r_ph == PH_JUMP))
        else $error("skip count outside a counted phase");
`endif

endmodule

### rtl/core/sebp_scale.sv
// divide-by-100 of the duration product and the output register
module sebp_scale (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_mid_valid,
    input  sebp_pkg::t_evt                      i_mid,
    output logic                                o_mid_take,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [sebp_pkg::OUT_DATA_W-1:0]     o_data,
    output logic [sebp_pkg::KIND_W-1:0]         o_kind
);

    logic                               r_valid;
    logic [sebp_pkg::OUT_DATA_W-1:0]    r_data;
    logic [sebp_pkg::KIND_W-1:0]        r_kind;
    logic [sebp_pkg::OUT_DATA_W-1:0]    n_data;

    logic [26:0] recip_prod;
    logic [9:0]  quot;
    logic [8:0]  nlen;
    logic [31:0] evt_time;
    logic        out_free;

    assign out_free   = !r_valid || i_ready;
    assign o_mid_take = i_mid_valid && out_free;

    // floor(p/100) as ((p >> 2) * 5243) >> 17
    assign recip_prod = 27'(i_mid.prod[15:2] * sebp_pkg::RECIP_100);
    assign quot       = recip_prod[sebp_pkg::RECIP_SHIFT +: 10];

    always_comb begin
        nlen     = 9'd0;
        evt_time = i_mid.time_tick;
        if (i_mid.kind == sebp_pkg::KIND_NOTE) begin
            nlen = (quot == 10'd0) ? 9'd1 : quot[8:0];
        end
        if (i_mid.kind == sebp_pkg::KIND_HOLD) begin
            evt_time = i_mid.time_tick + {22'd0, quot};
        end
        n_data = {6'd0, i_mid.seek, i_mid.value, nlen, i_mid.vel, i_mid.note,
                  i_mid.length, i_mid.offset, evt_time};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (out_free) begin
            r_valid <= i_mid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_mid_take) begin
            r_data <= n_data;
            r_kind <= i_mid.kind;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_kind  = r_kind;

endmodule
